// ===== design/zph_pkg.sv =====
// Shared types, key-table layout and decode helpers for the Zobrist hash core.
package zph_pkg;

  localparam int unsigned KeyCount  = 781;
  localparam int unsigned KeyAw     = 10;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned NumReads  = 6;
  localparam int unsigned ReadCntW  = 3;

  localparam logic [KeyAw-1:0] CastleBase = 10'd768;
  localparam logic [KeyAw-1:0] EpBase     = 10'd772;
  localparam logic [KeyAw-1:0] SideSlot   = 10'd780;
  localparam logic [KeyAw-1:0] LastSlot   = 10'd780;
  localparam logic [6:0]       NoSquare   = 7'd64;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_SQUARE = 2'd1,
    FN_TAIL   = 2'd2,
    FN_MOVE   = 2'd3
  } func_e;

  localparam logic [2:0] PT_PAWN = 3'd1;
  localparam logic [2:0] PT_KING = 3'd6;

  localparam logic [3:0] MK_QUIET      = 4'd0;
  localparam logic [3:0] MK_DOUBLE     = 4'd1;
  localparam logic [3:0] MK_PROMO_N    = 4'd4;
  localparam logic [3:0] MK_PROMO_Q    = 4'd7;
  localparam logic [3:0] MK_CAPTURE    = 4'd8;
  localparam logic [3:0] MK_EN_PASSANT = 4'd9;
  localparam logic [3:0] MK_PCAP_N     = 4'd10;
  localparam logic [3:0] MK_PCAP_Q     = 4'd13;

  // promotion kinds map onto piece types by a fixed offset
  localparam logic [3:0] PromoOffset    = 4'd2;
  localparam logic [3:0] PcapOffset     = 4'd8;

  typedef struct packed {
    logic             valid;
    logic [KeyAw-1:0] index;
  } slot_t;

  // One queued command: either a key write or a list of key reads to XOR.
  typedef struct packed {
    logic                     is_write;
    logic                     wr_en;
    logic [KeyAw-1:0]         wr_index;
    logic [KeyW-1:0]          wr_value;
    logic                     clear;
    logic                     rehash;
    logic [ReadCntW-1:0]      n_reads;
    slot_t [NumReads-1:0]     rd;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic slot_t piece_slot(logic [5:0] sq, logic [2:0] ptype, logic who);
    slot_t            s;
    logic [KeyAw-1:0] base;
    logic [2:0]       tm1;
    base    = (KeyAw'(sq) << 3) + (KeyAw'(sq) << 2);
    tm1     = ptype - 3'd1;
    s.valid = (ptype >= PT_PAWN) && (ptype <= PT_KING);
    s.index = base + KeyAw'({tm1, 1'b0}) + KeyAw'(who);
    return s;
  endfunction

  function automatic slot_t ep_slot(logic [6:0] ep);
    slot_t s;
    s.valid = (ep < NoSquare);
    s.index = EpBase + KeyAw'(ep[2:0]);
    return s;
  endfunction

endpackage

// ===== design/zph_if.sv =====
// Valid/ready channel interfaces for position items and hash results.
interface zph_in_if;
  import zph_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [9:0]  key_index;
  logic [63:0] key_value;
  logic [5:0]  from_square;
  logic [5:0]  to_square;
  logic [2:0]  piece_type;
  logic        player;
  logic [2:0]  victim_type;
  logic [3:0]  move_kind;
  logic [3:0]  castling;
  logic [6:0]  ep_square;

  modport source (
    output valid, func, key_index, key_value, from_square, to_square, piece_type,
           player, victim_type, move_kind, castling, ep_square,
    input  ready
  );
  modport sink (
    input  valid, func, key_index, key_value, from_square, to_square, piece_type,
           player, victim_type, move_kind, castling, ep_square,
    output ready
  );
endinterface

interface zph_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash;
  logic        need_rehash;

  modport source (output valid, hash, need_rehash, input ready);
  modport sink   (input valid, hash, need_rehash, output ready);
endinterface

// ===== design/zph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module zph_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 781
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/zph_front.sv =====
// Front end: accepts items, tracks castling/ep state, builds key-read commands.
module zph_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  zph_in_if.sink            item_i,
  input  zph_pkg::fifo_stat_t fifo_stat_i,
  output logic              push_o,
  output zph_pkg::cmd_t     cmd_o
);
  import zph_pkg::*;

  logic [3:0] held_castling_q, held_castling_d;
  logic [6:0] held_ep_q, held_ep_d;
  logic [6:0] ep_n;
  logic [5:0] cap_sq;
  logic       opp;

  assign item_i.ready = !fifo_stat_i.full;
  assign push_o       = item_i.valid && !fifo_stat_i.full;

  assign ep_n   = (item_i.ep_square > NoSquare) ? NoSquare : item_i.ep_square;
  assign opp    = ~item_i.player;
  // en-passant victim sits one rank behind the target, wrapping mod 64
  assign cap_sq = item_i.player ? (item_i.to_square + 6'd8) : (item_i.to_square - 6'd8);

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_index  = item_i.key_index;
    cmd_o.wr_value  = item_i.key_value;
    held_castling_d = held_castling_q;
    held_ep_d       = held_ep_q;
    case (item_i.func)
      FN_LOAD: begin
        cmd_o.is_write = 1'b1;
        cmd_o.wr_en    = (item_i.key_index <= LastSlot);
      end
      FN_SQUARE: begin
        cmd_o.clear   = (item_i.from_square == 6'd0);
        cmd_o.n_reads = ReadCntW'(1);
        cmd_o.rd[0]   = piece_slot(item_i.from_square, item_i.piece_type, item_i.player);
      end
      FN_TAIL: begin
        cmd_o.n_reads = ReadCntW'(NumReads);
        cmd_o.rd[0]   = ep_slot(ep_n);
        for (int i = 0; i < 4; i++) begin
          cmd_o.rd[i+1].valid = item_i.castling[i];
          cmd_o.rd[i+1].index = CastleBase + KeyAw'(i);
        end
        cmd_o.rd[5].valid = item_i.player;
        cmd_o.rd[5].index = SideSlot;
        held_castling_d   = item_i.castling;
        held_ep_d         = ep_n;
      end
      FN_MOVE: begin
        if (item_i.castling != held_castling_q) begin
          cmd_o.rehash    = 1'b1;
          held_castling_d = item_i.castling;
          held_ep_d       = ep_n;
        end else begin
          cmd_o.n_reads = ReadCntW'(NumReads);
          cmd_o.rd[0]   = piece_slot(item_i.from_square, item_i.piece_type, item_i.player);
          case (item_i.move_kind) inside
            [MK_QUIET:MK_DOUBLE]: begin
              cmd_o.rd[2] = piece_slot(item_i.to_square, item_i.piece_type, item_i.player);
            end
            [MK_PROMO_N:MK_PROMO_Q]: begin
              cmd_o.rd[2] = piece_slot(item_i.to_square,
                                       3'(item_i.move_kind - PromoOffset), item_i.player);
            end
            MK_CAPTURE: begin
              cmd_o.rd[1] = piece_slot(item_i.to_square, item_i.victim_type, opp);
              cmd_o.rd[2] = piece_slot(item_i.to_square, item_i.piece_type, item_i.player);
            end
            MK_EN_PASSANT: begin
              cmd_o.rd[1] = piece_slot(cap_sq, item_i.victim_type, opp);
              cmd_o.rd[2] = piece_slot(item_i.to_square, item_i.piece_type, item_i.player);
            end
            [MK_PCAP_N:MK_PCAP_Q]: begin
              cmd_o.rd[1] = piece_slot(item_i.to_square, item_i.victim_type, opp);
              cmd_o.rd[2] = piece_slot(item_i.to_square,
                                       3'(item_i.move_kind - PcapOffset), item_i.player);
            end
            default: ;
          endcase
          cmd_o.rd[3]       = ep_slot(held_ep_q);
          cmd_o.rd[4]       = ep_slot(ep_n);
          cmd_o.rd[5].valid = 1'b1;
          cmd_o.rd[5].index = SideSlot;
          held_ep_d         = ep_n;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_castling_q <= '0;
      held_ep_q       <= NoSquare;
    end else if (push_o) begin
      held_castling_q <= held_castling_d;
      held_ep_q       <= held_ep_d;
    end
  end

endmodule

// ===== design/zph_fifo.sv =====
// Short command queue between the front end and the back end.
module zph_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  zph_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output zph_pkg::cmd_t       cmd_o,
  output zph_pkg::fifo_stat_t stat_o
);
  import zph_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Depth));

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== design/zph_back.sv =====
// Back end: owns the key table, walks each command's key reads, XORs into the hash.
module zph_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  zph_pkg::cmd_t       cmd_i,
  input  zph_pkg::fifo_stat_t fifo_stat_i,
  output logic                pop_o,
  zph_out_if.source           result_o
);
  import zph_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cur_q, cur_d;
  logic [ReadCntW-1:0] idx_q, idx_d;
  logic [KeyW-1:0]     acc_q, acc_d, acc_x;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [KeyW-1:0]     out_hash_q;
  logic                out_rh_q, out_rh_d;
  logic                load_out, out_free;
  logic                ram_we;
  logic [KeyAw-1:0]    raddr;
  logic [KeyW-1:0]     rdata;

  zph_ram #(
    .Width (KeyW),
    .Depth (KeyCount)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.wr_index),
    .wdata_i (cmd_i.wr_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free             = !out_valid_q || result_o.ready;
  assign result_o.valid       = out_valid_q;
  assign result_o.hash        = out_hash_q;
  assign result_o.need_rehash = out_rh_q;

  // read data lands in the cycle after its address
  assign acc_x = pend_q ? (acc_q ^ rdata) : acc_q;
  assign raddr = cur_q.rd[idx_q].index;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    idx_d    = idx_q;
    acc_d    = acc_x;
    pend_d   = 1'b0;
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    out_rh_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!fifo_stat_i.empty) begin
          if (cmd_i.is_write || (cmd_i.n_reads == '0)) begin
            if (out_free) begin
              pop_o    = 1'b1;
              ram_we   = cmd_i.is_write && cmd_i.wr_en;
              load_out = 1'b1;
              out_rh_d = cmd_i.rehash;
            end
          end else begin
            pop_o   = 1'b1;
            cur_d   = cmd_i;
            idx_d   = '0;
            if (cmd_i.clear) begin
              acc_d = '0;
            end
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        pend_d = cur_q.rd[idx_q].valid;
        idx_d  = idx_q + ReadCntW'(1);
        if (idx_q == cur_q.n_reads - ReadCntW'(1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    if (load_out) begin
      out_hash_q <= acc_d;
      out_rh_q   <= out_rh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/zobrist_position_hash_core.sv =====
// Zobrist position hash core: input channel, command queue, key table and hash output.
//
// item_i carries one item per transfer: a key-table load, one square of a full
// position hash, the position tail (en-passant, castling, side to move) or a move.
// result_o returns exactly one result per item: the running hash after the item
// and need_rehash, set when a move changes castling rights (hash left untouched;
// the host then streams the full position followed by a tail item).
// The front end takes an item whenever the command queue has room, so new items
// are taken while earlier ones are still being hashed or waiting on result_o.
// The back end reads the 781-word key table one word per cycle from a single
// read port: a move or tail item takes a dequeue step, six key reads and a
// finishing step, a square item a dequeue step, one key read and a finishing
// step; a key load or a rehash move completes in its dequeue step.
// A full result register holds until taken; while result_o stalls the back end
// waits before finishing its item and the queue fills, then item_i.ready drops.
// Reset clears the hash to zero, castling rights to none and the en-passant
// target to none; the key table is not cleared and must be loaded before use.
module zobrist_position_hash_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  zph_in_if.sink    item_i,
  zph_out_if.source result_o
);
  import zph_pkg::*;

  cmd_t       push_cmd, head_cmd;
  logic       push, pop;
  fifo_stat_t fifo_stat;

  zph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  zph_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (fifo_stat)
  );

  zph_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .result_o    (result_o)
  );

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("queue popped while empty");

  a_full_by_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fifo_stat.full) |-> $past(push))
    else $error("queue became full without a transfer in");

  a_empty_by_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fifo_stat.empty) |-> $past(pop))
    else $error("queue drained without a pop");

endmodule

// ===== sim/tb_zobrist_position_hash_core.sv =====
// Self-checking testbench for zobrist_position_hash_core: key loads, full hashes and moves.
`timescale 1ns / 100ps

module tb_zobrist_position_hash_core;
  import zph_pkg::*;

  localparam logic [2:0]  PT_NONE     = 3'd0;
  localparam logic [2:0]  PT_KNIGHT   = 3'd2;
  localparam logic [2:0]  PT_ROOK     = 3'd4;
  localparam logic [2:0]  PT_QUEEN    = 3'd5;
  localparam logic [2:0]  PT_BAD      = 3'd7;
  localparam logic [3:0]  MK_CASTLE_K = 4'd2;
  localparam logic [3:0]  MK_CASTLE_Q = 4'd3;
  localparam logic [3:0]  MK_BAD_LO   = 4'd14;
  localparam logic [3:0]  MK_BAD_HI   = 4'd15;
  localparam logic [3:0]  RightsAll   = 4'hF;
  localparam logic [3:0]  RightsSome  = 4'h5;
  localparam logic [63:0] AllOnes     = '1;
  localparam logic        WHITE       = 1'b0;
  localparam logic        BLACK       = 1'b1;
  localparam int unsigned RandomItems = 120;
  localparam int unsigned DrainCycles = 32;

  typedef struct {
    func_e       func;
    logic [9:0]  key_index;
    logic [63:0] key_value;
    logic [5:0]  from_sq;
    logic [5:0]  to_sq;
    logic [2:0]  ptype;
    logic        who;
    logic [2:0]  ctype;
    logic [3:0]  kind;
    logic [3:0]  rights;
    logic [6:0]  ep;
  } pos_item_t;

  typedef struct {
    logic [63:0] hash;
    logic        rehash;
  } hash_result_t;

  typedef struct {
    pos_item_t    it;
    bit           typed;
    hash_result_t want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  zph_in_if  item_if ();
  zph_out_if res_if ();

  zobrist_position_hash_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if)
  );

  // predicted block state
  logic [63:0] zkeys [KeyCount];
  logic [63:0] run_hash    = '0;
  logic [3:0]  held_rights = '0;
  logic [6:0]  held_ep     = NoSquare;

  hash_result_t hashes_due [$];
  stim_row_t    dir_rows [$];
  hash_result_t res_due;

  int unsigned items_sent         = 0;
  int unsigned results_checked    = 0;
  int unsigned mismatches         = 0;
  int unsigned rehash_seen        = 0;
  int unsigned positions_streamed = 0;
  int unsigned ready_left         = 0;
  bit          full_speed         = 1'b0;

  function automatic logic [63:0] piece_word(logic [5:0] sq, logic [2:0] pt, logic side);
    if (pt < PT_PAWN || pt > PT_KING) return '0;
    return zkeys[int'(sq) * 12 + (int'(pt) - 1) * 2 + int'(side)];
  endfunction

  function automatic logic [63:0] ep_word(logic [6:0] ep);
    if (ep >= NoSquare) return '0;
    return zkeys[int'(EpBase) + int'(ep[2:0])];
  endfunction

  function automatic logic [63:0] rights_word(logic [3:0] rights);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < 4; i++)
      if (rights[i]) w ^= zkeys[int'(CastleBase) + i];
    return w;
  endfunction

  function automatic hash_result_t step_hash(input pos_item_t it);
    hash_result_t r;
    logic [63:0]  h;
    logic [6:0]   ep;
    logic [5:0]   cap_sq;
    h        = run_hash;
    r.rehash = 1'b0;
    ep       = (it.ep > NoSquare) ? NoSquare : it.ep;
    case (it.func)
      FN_LOAD: begin
        if (it.key_index < KeyCount) zkeys[it.key_index] = it.key_value;
      end
      FN_SQUARE: begin
        if (it.from_sq == 6'd0) h = '0;
        h ^= piece_word(it.from_sq, it.ptype, it.who);
      end
      FN_TAIL: begin
        h ^= ep_word(ep) ^ rights_word(it.rights);
        if (it.who) h ^= zkeys[SideSlot];
        held_rights = it.rights;
        held_ep     = ep;
      end
      FN_MOVE: begin
        if (it.rights != held_rights) begin
          // castling changed: hash untouched, host has to re-stream
          r.rehash    = 1'b1;
          held_rights = it.rights;
          held_ep     = ep;
        end else begin
          h ^= piece_word(it.from_sq, it.ptype, it.who);
          if (it.kind <= MK_DOUBLE) begin
            h ^= piece_word(it.to_sq, it.ptype, it.who);
          end else if (it.kind >= MK_PROMO_N && it.kind <= MK_PROMO_Q) begin
            h ^= piece_word(it.to_sq, 3'(it.kind - PromoOffset), it.who);
          end else if (it.kind == MK_CAPTURE || it.kind == MK_EN_PASSANT) begin
            cap_sq = it.to_sq;
            // victim of en passant sits one rank behind the target, wrapping
            if (it.kind == MK_EN_PASSANT) cap_sq = it.who ? it.to_sq + 6'd8 : it.to_sq - 6'd8;
            h ^= piece_word(cap_sq, it.ctype, ~it.who) ^ piece_word(it.to_sq, it.ptype, it.who);
          end else if (it.kind >= MK_PCAP_N && it.kind <= MK_PCAP_Q) begin
            h ^= piece_word(it.to_sq, it.ctype, ~it.who)
               ^ piece_word(it.to_sq, 3'(it.kind - PcapOffset), it.who);
          end
          h ^= ep_word(held_ep) ^ ep_word(ep) ^ zkeys[SideSlot];
          held_ep = ep;
        end
      end
    endcase
    run_hash = h;
    r.hash   = h;
    return r;
  endfunction

  function automatic int unsigned rand_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  function automatic logic [2:0] rand_piece();
    if ($urandom_range(0, 9) != 0) return 3'($urandom_range(1, 6));
    return $urandom_range(0, 1) ? PT_BAD : PT_NONE;
  endfunction

  function automatic logic [6:0] rand_ep();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return NoSquare;
    if (r < 92) return 7'($urandom_range(0, 63));
    return 7'($urandom_range(65, 127));
  endfunction

  // unused fields carry random noise
  function automatic pos_item_t noise_item(func_e f);
    pos_item_t it;
    it.func      = f;
    it.key_index = 10'($urandom);
    it.key_value = {$urandom, $urandom};
    it.from_sq   = 6'($urandom);
    it.to_sq     = 6'($urandom);
    it.ptype     = 3'($urandom);
    it.who       = 1'($urandom);
    it.ctype     = 3'($urandom);
    it.kind      = 4'($urandom);
    it.rights    = 4'($urandom);
    it.ep        = 7'($urandom);
    return it;
  endfunction

  function automatic pos_item_t item_load(logic [9:0] idx, logic [63:0] val);
    pos_item_t it;
    it           = noise_item(FN_LOAD);
    it.key_index = idx;
    it.key_value = val;
    return it;
  endfunction

  function automatic pos_item_t item_square(logic [5:0] sq, logic [2:0] pt, logic side);
    pos_item_t it;
    it         = noise_item(FN_SQUARE);
    it.from_sq = sq;
    it.ptype   = pt;
    it.who     = side;
    return it;
  endfunction

  function automatic pos_item_t item_tail(logic [6:0] ep, logic [3:0] rights, logic side);
    pos_item_t it;
    it        = noise_item(FN_TAIL);
    it.ep     = ep;
    it.rights = rights;
    it.who    = side;
    return it;
  endfunction

  function automatic pos_item_t item_move(logic [3:0] kind, logic [5:0] from_sq,
                                          logic [5:0] to_sq, logic [2:0] pt, logic side,
                                          logic [2:0] ct, logic [3:0] rights, logic [6:0] ep);
    pos_item_t it;
    it         = noise_item(FN_MOVE);
    it.kind    = kind;
    it.from_sq = from_sq;
    it.to_sq   = to_sq;
    it.ptype   = pt;
    it.who     = side;
    it.ctype   = ct;
    it.rights  = rights;
    it.ep      = ep;
    return it;
  endfunction

  function automatic void add_row(pos_item_t it, bit typed, logic [63:0] h, logic rh);
    stim_row_t row;
    row.it          = it;
    row.typed       = typed;
    row.want.hash   = h;
    row.want.rehash = rh;
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input pos_item_t it, input bit typed, input hash_result_t want);
    int unsigned  gap;
    hash_result_t pred;
    gap = full_speed ? 0 : rand_idle();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.func          <= it.func;
    item_if.key_index     <= it.key_index;
    item_if.key_value     <= it.key_value;
    item_if.from_square   <= it.from_sq;
    item_if.to_square     <= it.to_sq;
    item_if.piece_type    <= it.ptype;
    item_if.player        <= it.who;
    item_if.victim_type   <= it.ctype;
    item_if.move_kind     <= it.kind;
    item_if.castling      <= it.rights;
    item_if.ep_square     <= it.ep;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    pred = step_hash(it);
    hashes_due.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (hashes_due.size() == 0) begin
          $error("unexpected result: hash %h need_rehash %b", res_if.hash, res_if.need_rehash);
          mismatches++;
        end else begin
          res_due = hashes_due.pop_front();
          if (res_if.hash !== res_due.hash) begin
            $error("hash: expected %h, got %h", res_due.hash, res_if.hash);
            mismatches++;
          end
          if (res_if.need_rehash !== res_due.rehash) begin
            $error("need_rehash: expected %b, got %b", res_due.rehash, res_if.need_rehash);
            mismatches++;
          end
          if (res_due.rehash) rehash_seen++;
          results_checked++;
        end
      end
      if (ready_left != 0) begin
        ready_left--;
      end else if (full_speed || $urandom_range(0, 99) < 60) begin
        res_if.ready <= 1'b1;
        ready_left = $urandom_range(1, 12);
      end else begin
        res_if.ready <= 1'b0;
        ready_left = rand_idle() + 1;
      end
    end
  end

  initial begin : stimulus
    hash_result_t no_want;
    int unsigned  stop_at;
    int unsigned  pick;
    int unsigned  span;
    logic [3:0]   new_rights;
    no_want.hash          = '0;
    no_want.rehash        = 1'b0;
    item_if.valid         = 1'b0;
    item_if.func          = FN_LOAD;
    item_if.key_index     = '0;
    item_if.key_value     = '0;
    item_if.from_square   = '0;
    item_if.to_square     = '0;
    item_if.piece_type    = '0;
    item_if.player        = 1'b0;
    item_if.victim_type   = '0;
    item_if.move_kind     = '0;
    item_if.castling      = '0;
    item_if.ep_square     = '0;
    res_if.ready          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole key table first, so nothing later reads an unloaded slot
    for (int unsigned i = 0; i < KeyCount; i++)
      send_item(item_load(10'(i), {$urandom, $urandom}), 1'b0, no_want);

    // directed: reset state, ignored loads, extreme slots, each group of move kinds
    add_row(item_move(MK_QUIET, 6'd12, 6'd20, PT_PAWN, WHITE, PT_NONE, RightsAll, NoSquare),
            1'b1, '0, 1'b1);
    add_row(item_load(10'd1023, AllOnes), 1'b1, '0, 1'b0);
    add_row(item_load(10'd781, AllOnes), 1'b1, '0, 1'b0);
    add_row(item_load(SideSlot, AllOnes), 1'b1, '0, 1'b0);
    add_row(item_load(10'd0, '0), 1'b1, '0, 1'b0);
    add_row(item_load(10'd767, AllOnes), 1'b1, '0, 1'b0);
    add_row(item_square(6'd0, PT_PAWN, WHITE), 1'b1, '0, 1'b0);
    add_row(item_square(6'd63, PT_KING, BLACK), 1'b1, AllOnes, 1'b0);
    add_row(item_square(6'd5, PT_NONE, WHITE), 1'b0, '0, 1'b0);
    add_row(item_square(6'd6, PT_BAD, BLACK), 1'b0, '0, 1'b0);
    add_row(item_tail(7'd20, RightsAll, BLACK), 1'b0, '0, 1'b0);
    // same en-passant file: old and new keys cancel
    add_row(item_move(MK_QUIET, 6'd52, 6'd44, PT_PAWN, BLACK, PT_NONE, RightsAll, 7'd28),
            1'b0, '0, 1'b0);
    // target moves between files: both keys
    add_row(item_move(MK_DOUBLE, 6'd13, 6'd29, PT_PAWN, WHITE, PT_NONE, RightsAll, 7'd45),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_CASTLE_K, 6'd60, 6'd62, PT_KING, BLACK, PT_NONE, RightsAll, NoSquare),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_CASTLE_Q, 6'd4, 6'd2, PT_KING, WHITE, PT_NONE, RightsAll, 7'd127),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_PROMO_N, 6'd49, 6'd57, PT_PAWN, WHITE, PT_NONE, RightsAll, 7'd65),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_PROMO_Q, 6'd9, 6'd1, PT_PAWN, BLACK, PT_NONE, RightsAll, NoSquare),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_CAPTURE, 6'd3, 6'd59, PT_QUEEN, WHITE, PT_ROOK, RightsAll, NoSquare),
            1'b0, '0, 1'b0);
    // en-passant victim square wraps around the board
    add_row(item_move(MK_EN_PASSANT, 6'd9, 6'd2, PT_PAWN, WHITE, PT_PAWN, RightsAll, 7'd2),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_EN_PASSANT, 6'd51, 6'd60, PT_PAWN, BLACK, PT_PAWN, RightsAll, NoSquare),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_PCAP_N, 6'd54, 6'd63, PT_PAWN, WHITE, PT_KNIGHT, RightsAll, NoSquare),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_PCAP_Q, 6'd14, 6'd7, PT_PAWN, BLACK, PT_KING, RightsAll, 7'd40),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_BAD_LO, 6'd20, 6'd30, PT_ROOK, WHITE, PT_QUEEN, RightsAll, NoSquare),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_BAD_HI, 6'd33, 6'd40, PT_BAD, BLACK, PT_BAD, RightsAll, 7'd16),
            1'b0, '0, 1'b0);
    add_row(item_move(MK_QUIET, 6'd7, 6'd5, PT_ROOK, WHITE, PT_NONE, RightsSome, NoSquare),
            1'b0, '0, 1'b1);
    add_row(item_square(6'd0, PT_KNIGHT, BLACK), 1'b0, '0, 1'b0);
    add_row(item_tail(NoSquare, RightsSome, WHITE), 1'b0, '0, 1'b0);
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // random: mostly legal-rights moves, with rehash-and-restream sequences mixed in
    stop_at = items_sent + RandomItems;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) full_speed = !full_speed;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_item(item_move(4'($urandom), 6'($urandom), 6'($urandom), rand_piece(),
                            1'($urandom), rand_piece(), held_rights, rand_ep()),
                  1'b0, no_want);
      end else if (pick < 70) begin
        new_rights = 4'($urandom);
        if (new_rights == held_rights) new_rights = ~new_rights;
        send_item(item_move(4'($urandom), 6'($urandom), 6'($urandom), rand_piece(),
                            1'($urandom), rand_piece(), new_rights, rand_ep()),
                  1'b0, no_want);
        span = ($urandom_range(0, 11) == 0) ? 64 : $urandom_range(1, 12);
        for (int unsigned s = 0; s < span; s++)
          send_item(item_square((span == 64 || s == 0) ? 6'(s) : 6'($urandom),
                                ($urandom_range(0, 9) < 4) ? PT_NONE : rand_piece(),
                                1'($urandom)),
                    1'b0, no_want);
        send_item(item_tail(rand_ep(), new_rights, 1'($urandom)), 1'b0, no_want);
        positions_streamed++;
      end else if (pick < 78) begin
        send_item(item_square(6'($urandom), rand_piece(), 1'($urandom)), 1'b0, no_want);
      end else if (pick < 85) begin
        send_item(item_tail(rand_ep(), 4'($urandom), 1'($urandom)), 1'b0, no_want);
      end else if (pick < 92) begin
        send_item(item_load(10'($urandom_range(0, 1023)), {$urandom, $urandom}),
                  1'b0, no_want);
      end else begin
        send_item(noise_item(func_e'($urandom_range(0, 3))), 1'b0, no_want);
      end
    end
    item_if.valid <= 1'b0;

    while (hashes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results, %0d of them rehash requests.",
             items_sent, results_checked, rehash_seen);
    $display("Positions re-streamed after castling changes: %0d; all move kinds exercised.",
             positions_streamed);
    if (mismatches == 0 && hashes_due.size() == 0) begin
      $display("** zobrist_position_hash_core: PASSED **");
    end else begin
      $display("** zobrist_position_hash_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd8_000_000);
    $display("** zobrist_position_hash_core: FAILED **");
    $finish;
  end

endmodule
